FILE: rtl/ecsm_pkg.sv
// Package for the elliptic-curve scalar multiplier: port widths, field
// defaults and configuration register indexes. No dependencies.
`timescale 1ns / 1ps

package ecsm_pkg;

   // Fixed width of every coordinate, scalar and register field on the ports.
   localparam int DATA_W = 63;

   // Default number of field bits actually used inside the block.
   localparam int FIELD_BITS_DEF = 63;

   // Beat payload widths, padded to whole bytes.
   localparam int REQ_TDATA_W = 192;
   localparam int RSP_TDATA_W = 128;

   // Configuration port.
   localparam int CSR_ADDR_W = 1;
   localparam logic [CSR_ADDR_W-1:0] CSR_FIELD_MODULUS = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_CURVE_A       = 1'b1;

   // Reset value of the field modulus register.
   localparam logic [DATA_W-1:0] MODULUS_RESET = 63'd3;

endpackage

FILE: rtl/ec_point_scalar_multiply.sv
// Elliptic-curve scalar multiplication over a prime field, affine coordinates.
// Uses ecsm_pkg for port widths and configuration register indexes.
`timescale 1ns / 1ps

// How the block is used:
// The request channel (req_*) carries one beat per job: the scalar k and the
// affine base point in req_tdata, and the point-at-infinity flag in req_tuser.
// The response channel (rsp_*) returns one beat per job holding k times the
// point; an infinite result has zero coordinates and rsp_tuser set.
// The field modulus q and curve coefficient a are written through the csr_*
// port; the user is to write them only while the block is idle, since the
// block itself does not enforce this. A modulus below 3 is treated as 3. The
// block works on one job at a time. Every field multiplication is a bit-serial
// shift-and-add loop, and this shared multiplier sets the pace. A modular
// inverse (Fermat, q-2 exponent) takes up to 2 * FIELD_BITS multiplications.
// Each scalar bit costs a doubling and, when set, an addition, each with one
// inverse and up to four more products.
// A finished result sits in an output register, so the next request beat is
// taken while the result still waits for rsp_tready; a stalled receiver holds
// back the following job only when it is done before the previous result left.
// Reset is synchronous: the modulus returns to 3, a to 0, and no beat is held.

module ec_point_scalar_multiply #(
   parameter int FIELD_BITS = ecsm_pkg::FIELD_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // Request: [62:0] scalar, [125:63] point_x, [188:126] point_y, zero padding.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [ecsm_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // Request: [0] point_at_infinity.
   input  logic                                req_tuser,
   // Response: [62:0] result_x, [125:63] result_y, zero padding.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [ecsm_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   // Response: [0] result_at_infinity.
   output logic                                rsp_tuser,
   // Configuration writes.
   input  logic                                csr_we,
   input  logic [ecsm_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [ecsm_pkg::DATA_W-1:0]         csr_wdata
);

   localparam int W  = FIELD_BITS;
   localparam int DW = ecsm_pkg::DATA_W;
   localparam int CW = $clog2(W + 1);

   typedef enum logic [22:0] {
      S_IDLE     = 23'b1 << 0,
      S_RED_A    = 23'b1 << 1,
      S_RED_X    = 23'b1 << 2,
      S_RED_Y    = 23'b1 << 3,
      S_LOOP     = 23'b1 << 4,
      S_ADD_CHK  = 23'b1 << 5,
      S_DBL_CHK  = 23'b1 << 6,
      S_DBL_SQ   = 23'b1 << 7,
      S_DBL_T2   = 23'b1 << 8,
      S_DBL_T3   = 23'b1 << 9,
      S_DBL_T4   = 23'b1 << 10,
      S_INV_INIT = 23'b1 << 11,
      S_INV_CHK  = 23'b1 << 12,
      S_INV_MULR = 23'b1 << 13,
      S_INV_SQ   = 23'b1 << 14,
      S_S_MUL    = 23'b1 << 15,
      S_S_SQ     = 23'b1 << 16,
      S_X_SUM    = 23'b1 << 17,
      S_X3       = 23'b1 << 18,
      S_DIFF     = 23'b1 << 19,
      S_Y_MUL    = 23'b1 << 20,
      S_Y3       = 23'b1 << 21,
      S_DONE     = 23'b1 << 22
   } state_type;

   function automatic logic [W-1:0] f_add(input logic [W-1:0] x, input logic [W-1:0] y,
                                          input logic [W-1:0] m);
      logic [W:0] s;
      s = {1'b0, x} + {1'b0, y};
      if (s >= {1'b0, m}) begin
         s = s - {1'b0, m};
      end
      return s[W-1:0];
   endfunction

   function automatic logic [W-1:0] f_sub(input logic [W-1:0] x, input logic [W-1:0] y,
                                          input logic [W-1:0] m);
      logic [W-1:0] d;
      d = x - y;
      if (x < y) begin
         d = d + m;
      end
      return d;
   endfunction

   // Control registers.
   state_type      state_ff, state_in;
   logic           out_valid_ff, out_valid_in;
   logic           mul_act_ff, mul_act_in;
   logic [DW-1:0]  modulus_ff, modulus_in;
   logic [DW-1:0]  curve_a_ff, curve_a_in;

   // Datapath registers.
   logic [W-1:0]   q_ff, q_in;
   logic [W-1:0]   a_ff, a_in;
   logic [W-1:0]   k_ff, k_in;
   logic [W-1:0]   px_ff, px_in, py_ff, py_in;
   logic           pinf_ff, pinf_in;
   logic [W-1:0]   ax_ff, ax_in, ay_ff, ay_in;
   logic           ainf_ff, ainf_in;
   logic           dst_acc_ff, dst_acc_in;
   logic [W-1:0]   num_ff, num_in, den_ff, den_in;
   logic [W-1:0]   x2_ff, x2_in, s_ff, s_in, tmp_ff, tmp_in;
   logic [W-1:0]   inv_r_ff, inv_r_in, inv_b_ff, inv_b_in, exp_ff, exp_in;
   logic [W-1:0]   mx_ff, mx_in, my_ff, my_in, mr_ff, mr_in;
   logic [CW-1:0]  mul_cnt_ff, mul_cnt_in;
   logic [DW-1:0]  out_x_ff, out_x_in, out_y_ff, out_y_in;
   logic           out_inf_ff, out_inf_in;

   // Multiplier operand selection and step.
   logic [W-1:0]   sel_x, sel_y, mul_dbl, mul_step;
   logic           mul_state, mul_fin;
   logic [W-1:0]   x3_val, y3_val, modulus_w;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(ecsm_pkg::RSP_TDATA_W - 2 * DW){1'b0}}, out_y_ff, out_x_ff};
   assign rsp_tuser  = out_inf_ff;

   assign modulus_w = modulus_ff[W-1:0];
   assign mul_dbl   = f_add(mr_ff, mr_ff, q_ff);
   assign mul_step  = my_ff[W-1] ? f_add(mul_dbl, mx_ff, q_ff) : mul_dbl;
   assign mul_fin   = mul_act_ff && (mul_cnt_ff == '0);
   assign x3_val    = num_ff;
   assign y3_val    = f_sub(tmp_ff, py_ff, q_ff);

   // Reduction of an operand is a product with one.
   always_comb begin
      mul_state = 1'b1;
      sel_x     = px_ff;
      sel_y     = px_ff;
      case (state_ff)
         S_RED_A: begin
            sel_x = W'(1);
            sel_y = curve_a_ff[W-1:0];
         end
         S_RED_X: begin
            sel_x = W'(1);
            sel_y = px_ff;
         end
         S_RED_Y: begin
            sel_x = W'(1);
            sel_y = py_ff;
         end
         S_DBL_SQ: begin
            sel_x = px_ff;
            sel_y = px_ff;
         end
         S_INV_MULR: begin
            sel_x = inv_r_ff;
            sel_y = inv_b_ff;
         end
         S_INV_SQ: begin
            sel_x = inv_b_ff;
            sel_y = inv_b_ff;
         end
         S_S_MUL: begin
            sel_x = num_ff;
            sel_y = inv_r_ff;
         end
         S_S_SQ: begin
            sel_x = s_ff;
            sel_y = s_ff;
         end
         S_Y_MUL: begin
            sel_x = s_ff;
            sel_y = tmp_ff;
         end
         default: begin
            mul_state = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      out_valid_in = out_valid_ff;
      mul_act_in   = mul_act_ff;
      modulus_in   = modulus_ff;
      curve_a_in   = curve_a_ff;
      q_in         = q_ff;
      a_in         = a_ff;
      k_in         = k_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      pinf_in      = pinf_ff;
      ax_in        = ax_ff;
      ay_in        = ay_ff;
      ainf_in      = ainf_ff;
      dst_acc_in   = dst_acc_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      x2_in        = x2_ff;
      s_in         = s_ff;
      tmp_in       = tmp_ff;
      inv_r_in     = inv_r_ff;
      inv_b_in     = inv_b_ff;
      exp_in       = exp_ff;
      mx_in        = mx_ff;
      my_in        = my_ff;
      mr_in        = mr_ff;
      mul_cnt_in   = mul_cnt_ff;
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      out_inf_in   = out_inf_ff;

      if (csr_we) begin
         unique case (csr_addr)
            ecsm_pkg::CSR_FIELD_MODULUS: modulus_in = csr_wdata;
            ecsm_pkg::CSR_CURVE_A:       curve_a_in = csr_wdata;
            default: ;
         endcase
      end

      if (out_valid_ff && rsp_tready) begin
         out_valid_in = 1'b0;
      end

      // Shared bit-serial multiplier: load, then one multiplier bit a cycle.
      if (mul_state) begin
         if (!mul_act_ff) begin
            mx_in      = sel_x;
            my_in      = sel_y;
            mr_in      = '0;
            mul_cnt_in = CW'(W);
            mul_act_in = 1'b1;
         end else if (!mul_fin) begin
            mr_in      = mul_step;
            my_in      = {my_ff[W-2:0], 1'b0};
            mul_cnt_in = mul_cnt_ff - CW'(1);
         end else begin
            mul_act_in = 1'b0;
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               k_in       = req_tdata[W-1:0];
               px_in      = req_tdata[DW +: W];
               py_in      = req_tdata[2 * DW +: W];
               pinf_in    = req_tuser;
               q_in       = (modulus_w < W'(3)) ? W'(3) : modulus_w;
               ax_in      = '0;
               ay_in      = '0;
               ainf_in    = 1'b1;
               dst_acc_in = 1'b0;
               state_in   = S_RED_A;
            end
         end
         S_RED_A: begin
            if (mul_fin) begin
               a_in     = mr_ff;
               state_in = S_RED_X;
            end
         end
         S_RED_X: begin
            if (mul_fin) begin
               px_in    = mr_ff;
               state_in = S_RED_Y;
            end
         end
         S_RED_Y: begin
            if (mul_fin) begin
               py_in    = mr_ff;
               state_in = S_LOOP;
            end
         end
         S_LOOP: begin
            // Once the running point is infinite the accumulator cannot change.
            if (k_ff == '0 || pinf_ff) begin
               state_in = S_DONE;
            end else if (k_ff[0]) begin
               state_in = S_ADD_CHK;
            end else begin
               state_in = S_DBL_CHK;
            end
         end
         S_ADD_CHK: begin
            state_in = S_DBL_CHK;
            if (ainf_ff) begin
               ax_in   = px_ff;
               ay_in   = py_ff;
               ainf_in = 1'b0;
            end else if (px_ff == ax_ff && f_add(py_ff, ay_ff, q_ff) == '0) begin
               ax_in   = '0;
               ay_in   = '0;
               ainf_in = 1'b1;
            end else if (px_ff == ax_ff && py_ff == ay_ff) begin
               // Equal points: the sum is a doubling written to the accumulator.
               dst_acc_in = 1'b1;
            end else begin
               num_in     = f_sub(ay_ff, py_ff, q_ff);
               den_in     = f_sub(ax_ff, px_ff, q_ff);
               x2_in      = ax_ff;
               dst_acc_in = 1'b1;
               state_in   = S_INV_INIT;
            end
         end
         S_DBL_CHK: begin
            if (pinf_ff || py_ff == '0) begin
               if (dst_acc_ff) begin
                  ax_in      = '0;
                  ay_in      = '0;
                  ainf_in    = 1'b1;
                  dst_acc_in = 1'b0;
                  state_in   = S_DBL_CHK;
               end else begin
                  px_in    = '0;
                  py_in    = '0;
                  pinf_in  = 1'b1;
                  k_in     = k_ff >> 1;
                  state_in = S_LOOP;
               end
            end else begin
               state_in = S_DBL_SQ;
            end
         end
         S_DBL_SQ: begin
            if (mul_fin) begin
               tmp_in   = mr_ff;
               state_in = S_DBL_T2;
            end
         end
         S_DBL_T2: begin
            num_in   = f_add(tmp_ff, tmp_ff, q_ff);
            state_in = S_DBL_T3;
         end
         S_DBL_T3: begin
            num_in   = f_add(num_ff, tmp_ff, q_ff);
            state_in = S_DBL_T4;
         end
         S_DBL_T4: begin
            num_in   = f_add(num_ff, a_ff, q_ff);
            den_in   = f_add(py_ff, py_ff, q_ff);
            x2_in    = px_ff;
            state_in = S_INV_INIT;
         end
         S_INV_INIT: begin
            inv_r_in = W'(1);
            inv_b_in = den_ff;
            exp_in   = q_ff - W'(2);
            state_in = S_INV_CHK;
         end
         S_INV_CHK: begin
            if (exp_ff == '0) begin
               state_in = S_S_MUL;
            end else if (exp_ff[0]) begin
               state_in = S_INV_MULR;
            end else begin
               state_in = S_INV_SQ;
            end
         end
         S_INV_MULR: begin
            if (mul_fin) begin
               inv_r_in = mr_ff;
               state_in = S_INV_SQ;
            end
         end
         S_INV_SQ: begin
            if (mul_fin) begin
               inv_b_in = mr_ff;
               exp_in   = exp_ff >> 1;
               state_in = S_INV_CHK;
            end
         end
         S_S_MUL: begin
            if (mul_fin) begin
               s_in     = mr_ff;
               state_in = S_S_SQ;
            end
         end
         S_S_SQ: begin
            if (mul_fin) begin
               tmp_in   = mr_ff;
               state_in = S_X_SUM;
            end
         end
         S_X_SUM: begin
            x2_in    = f_add(px_ff, x2_ff, q_ff);
            state_in = S_X3;
         end
         S_X3: begin
            num_in   = f_sub(tmp_ff, x2_ff, q_ff);
            state_in = S_DIFF;
         end
         S_DIFF: begin
            tmp_in   = f_sub(px_ff, num_ff, q_ff);
            state_in = S_Y_MUL;
         end
         S_Y_MUL: begin
            if (mul_fin) begin
               tmp_in   = mr_ff;
               state_in = S_Y3;
            end
         end
         S_Y3: begin
            if (dst_acc_ff) begin
               ax_in      = x3_val;
               ay_in      = y3_val;
               ainf_in    = 1'b0;
               dst_acc_in = 1'b0;
               state_in   = S_DBL_CHK;
            end else begin
               px_in    = x3_val;
               py_in    = y3_val;
               k_in     = k_ff >> 1;
               state_in = S_LOOP;
            end
         end
         S_DONE: begin
            if (!out_valid_ff) begin
               out_x_in     = ainf_ff ? '0 : DW'(ax_ff);
               out_y_in     = ainf_ff ? '0 : DW'(ay_ff);
               out_inf_in   = ainf_ff;
               out_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
         mul_act_ff   <= 1'b0;
         modulus_ff   <= ecsm_pkg::MODULUS_RESET;
         curve_a_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         mul_act_ff   <= mul_act_in;
         modulus_ff   <= modulus_in;
         curve_a_ff   <= curve_a_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff       <= q_in;
      a_ff       <= a_in;
      k_ff       <= k_in;
      px_ff      <= px_in;
      py_ff      <= py_in;
      pinf_ff    <= pinf_in;
      ax_ff      <= ax_in;
      ay_ff      <= ay_in;
      ainf_ff    <= ainf_in;
      dst_acc_ff <= dst_acc_in;
      num_ff     <= num_in;
      den_ff     <= den_in;
      x2_ff      <= x2_in;
      s_ff       <= s_in;
      tmp_ff     <= tmp_in;
      inv_r_ff   <= inv_r_in;
      inv_b_ff   <= inv_b_in;
      exp_ff     <= exp_in;
      mx_ff      <= mx_in;
      my_ff      <= my_in;
      mr_ff      <= mr_in;
      mul_cnt_ff <= mul_cnt_in;
      out_x_ff   <= out_x_in;
      out_y_ff   <= out_y_in;
      out_inf_ff <= out_inf_in;
   end

endmodule
